// ----- design/panel_motor_pwm_controller_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the panel motor PWM controller
// Shared helpers for the concurrent checks of the controller ports.
// ----------------------------------------------------------------------------
`ifndef PANEL_MOTOR_PWM_CONTROLLER_CORE_MACROS_SVH
`define PANEL_MOTOR_PWM_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PMPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmpc check failed");

// Next-cycle implication, checked out of reset.
`define PMPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmpc check failed");

// Next-cycle implication that also holds through reset.
`define PMPC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pmpc check failed");

`endif

// ----- design/pmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Panel motor PWM controller package
// Widths, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package pmpc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned UNIT_W   = 10;  // period / 100 fits below 1024

  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  // floor(x / 100) for 16-bit x as (x * RECIP) >> RECIP_SHIFT
  localparam int unsigned       RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP      = 17'd83887;
  localparam int unsigned       RECIP_SHIFT = 23;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [DUTY_W-1:0]   STEP_RST   = 7'd10;
  localparam logic [UNIT_W-1:0]   UNIT_RST   = 10'd10;

  typedef enum logic [0:0] {
    CFG_PERIOD = 1'b0,
    CFG_STEP   = 1'b1
  } cfg_idx_t;

endpackage

// ----- design/panel_motor_pwm_controller_core.sv -----
// Path: an accepted request is registered in the input stage, then in the result stage,
// where it is held until taken. Throughput: one request per cycle unless out_ready stalls;
// the only loop is the state update inside the result stage.
// Stalls: out_ready low holds the result and, once the input stage is full, lowers in_ready.
// Reset: synchronous active-low rst_n empties both stages, clears duty, panel bit, pending
// flags and pin level, and loads period 1000, step 10 and next change time 1000.
// ----------------------------------------------------------------------------
// Panel motor PWM controller core
// Latches speed and panel requests, steps a clamped duty value, toggles the
// panel state and runs a software PWM on the motor pin, one tick per request.
// ----------------------------------------------------------------------------
module panel_motor_pwm_controller_core import pmpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  // tick request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TIME_W-1:0]   in_time_ms,
  input  logic                in_connected,
  input  logic                in_moving,
  input  logic                in_speed_up_req,
  input  logic                in_speed_down_req,
  input  logic                in_deploy_req,
  input  logic                in_retract_req,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_drive_on,
  output logic [DUTY_W-1:0]   out_drive_speed,
  output logic                out_panel_toggled_state
);

  // --------------------------------------------------------------------------
  // Configuration registers. The PWM unit (period / 100) is worked out once
  // per period write with a reciprocal multiply, so the tick path only sees
  // one small multiply.
  // --------------------------------------------------------------------------
  logic [PERIOD_W-1:0]         period_r;
  logic [DUTY_W-1:0]           step_r;
  logic [UNIT_W-1:0]           unit_r;
  logic [PERIOD_W+RECIP_W-1:0] unit_prod;

  assign unit_prod = {{RECIP_W{1'b0}}, cfg_wdata} * {{PERIOD_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      step_r   <= STEP_RST;
      unit_r   <= UNIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PERIOD: begin
          period_r <= cfg_wdata;
          unit_r   <= unit_prod[RECIP_SHIFT +: UNIT_W];
        end
        CFG_STEP: begin
          step_r <= cfg_wdata[DUTY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The result register frees up when empty or taken; the input
  // stage advances into it whenever it is free.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic res_free;
  logic s1_adv;
  logic in_acc;

  assign res_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && res_free;
  assign in_ready = !s1_valid_r || res_free;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (res_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Input stage payload: hold until the stage advances.
  logic [TIME_W-1:0] s1_time_r;
  logic              s1_conn_r;
  logic              s1_moving_r;
  logic              s1_up_r;
  logic              s1_down_r;
  logic              s1_deploy_r;
  logic              s1_retract_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_time_r    <= in_time_ms;
      s1_conn_r    <= in_connected;
      s1_moving_r  <= in_moving;
      s1_up_r      <= in_speed_up_req;
      s1_down_r    <= in_speed_down_req;
      s1_deploy_r  <= in_deploy_req;
      s1_retract_r <= in_retract_req;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state, updated as the input stage moves into the result stage.
  // --------------------------------------------------------------------------
  logic [DUTY_W-1:0] duty_r,    duty_nxt;
  logic              panel_r,   panel_nxt;
  logic              up_r,      up_nxt;
  logic              down_r,    down_nxt;
  logic              deploy_r,  deploy_nxt;
  logic              retract_r, retract_nxt;
  logic              pin_r,     pin_nxt;
  logic [TIME_W-1:0] nct_r,     nct_nxt;

  logic signed [DUTY_W+1:0] duty_sum;
  logic [DUTY_W-1:0]        run_duty;
  logic [DUTY_W-1:0]        span_mult;
  logic [UNIT_W+DUTY_W-1:0] span;
  logic [TIME_W-1:0]        t_plus_period;
  logic [TIME_W-1:0]        t_plus_span;
  logic                     run_en;

  always_comb begin
    // latch fresh pulses into the pending flags
    up_nxt      = up_r      | s1_up_r;
    down_nxt    = down_r    | s1_down_r;
    deploy_nxt  = deploy_r  | s1_deploy_r;
    retract_nxt = retract_r | s1_retract_r;
    duty_nxt    = duty_r;
    panel_nxt   = panel_r;
    run_en      = 1'b0;

    // duty step: add and subtract before the clamp, as one signed sum
    duty_sum = $signed({2'b00, duty_r});
    if (up_nxt) begin
      duty_sum = duty_sum + $signed({2'b00, step_r});
    end
    if (down_nxt) begin
      duty_sum = duty_sum - $signed({2'b00, step_r});
    end

    if (s1_conn_r) begin
      up_nxt   = 1'b0;
      down_nxt = 1'b0;
      if (duty_sum < 0) begin
        duty_nxt = '0;
      end else if (duty_sum > $signed({2'b00, DUTY_FULL})) begin
        duty_nxt = DUTY_FULL;
      end else begin
        duty_nxt = duty_sum[DUTY_W-1:0];
      end
      // a panel request while parked flips the panel and stops the motor
      if (!s1_moving_r && (deploy_nxt || retract_nxt)) begin
        panel_nxt   = !panel_r;
        duty_nxt    = '0;
        deploy_nxt  = 1'b0;
        retract_nxt = 1'b0;
      end
      run_en = s1_moving_r && ((panel_nxt && retract_nxt) || deploy_nxt);
    end

    // software PWM
    run_duty      = run_en ? duty_nxt : '0;
    span_mult     = pin_r ? (DUTY_FULL - run_duty) : run_duty;
    span          = {{DUTY_W{1'b0}}, unit_r} * {{UNIT_W{1'b0}}, span_mult};
    t_plus_period = s1_time_r + {{(TIME_W-PERIOD_W){1'b0}}, period_r};
    t_plus_span   = s1_time_r + {{(TIME_W-UNIT_W-DUTY_W){1'b0}}, span};
    pin_nxt       = pin_r;
    nct_nxt       = nct_r;
    if (run_duty == '0) begin
      pin_nxt = 1'b0;
      nct_nxt = t_plus_period;
    end else if (run_duty == DUTY_FULL) begin
      pin_nxt = 1'b1;
      nct_nxt = t_plus_period;
    end else if (s1_time_r > nct_r) begin
      pin_nxt = !pin_r;
      nct_nxt = t_plus_span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r    <= '0;
      panel_r   <= 1'b0;
      up_r      <= 1'b0;
      down_r    <= 1'b0;
      deploy_r  <= 1'b0;
      retract_r <= 1'b0;
      pin_r     <= 1'b0;
      nct_r     <= {{(TIME_W-PERIOD_W){1'b0}}, PERIOD_RST};
    end else if (s1_adv) begin
      duty_r    <= duty_nxt;
      panel_r   <= panel_nxt;
      up_r      <= up_nxt;
      down_r    <= down_nxt;
      deploy_r  <= deploy_nxt;
      retract_r <= retract_nxt;
      pin_r     <= pin_nxt;
      nct_r     <= nct_nxt;
    end
  end

  // Result register: hold while stalled.
  logic              drive_on_r;
  logic [DUTY_W-1:0] drive_speed_r;
  logic              panel_out_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive_on_r    <= pin_nxt;
      drive_speed_r <= duty_nxt;
      panel_out_r   <= panel_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_drive_on            = drive_on_r;
  assign out_drive_speed         = drive_speed_r;
  assign out_panel_toggled_state = panel_out_r;

endmodule

// ----- design/pmpc_checker.sv -----
// ----------------------------------------------------------------------------
// Panel motor PWM controller port checker
// Concurrent checks on the controller ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "panel_motor_pwm_controller_core_macros.svh"

module pmpc_checker import pmpc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                cfg_we,
  input logic                cfg_addr,
  input logic [PERIOD_W-1:0] cfg_wdata,
  input logic                in_valid,
  input logic                in_ready,
  input logic [TIME_W-1:0]   in_time_ms,
  input logic                in_connected,
  input logic                in_moving,
  input logic                in_speed_up_req,
  input logic                in_speed_down_req,
  input logic                in_deploy_req,
  input logic                in_retract_req,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_drive_on,
  input logic [DUTY_W-1:0]   out_drive_speed,
  input logic                out_panel_toggled_state
);

  // a stalled result holds
  `PMPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive_on) && $stable(out_drive_speed) && $stable(out_panel_toggled_state))

  // duty stays clamped
  `PMPC_ASSERT_NOW(a_speed_range, out_valid, out_drive_speed <= DUTY_FULL)

  // zero duty always parks the pin low
  `PMPC_ASSERT_NOW(a_zero_duty_low, out_valid && (out_drive_speed == '0), !out_drive_on)

  // reset empties the result stage
  `PMPC_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind panel_motor_pwm_controller_core pmpc_checker u_pmpc_checker (.*);

// ----- test/pmpc_drive_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drive result checker for the panel motor PWM controller
// Watches the request, result and configuration ports, predicts each tick and
// compares every result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module pmpc_drive_checker import pmpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [TIME_W-1:0]   in_time_ms,
  input  logic                in_connected,
  input  logic                in_moving,
  input  logic                in_speed_up_req,
  input  logic                in_speed_down_req,
  input  logic                in_deploy_req,
  input  logic                in_retract_req,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_drive_on,
  input  logic [DUTY_W-1:0]   out_drive_speed,
  input  logic                out_panel_toggled_state,
  output int                  fail_count,
  output int                  outstanding
);

  typedef struct packed {
    logic              drive_on;
    logic [DUTY_W-1:0] speed;
    logic              panel;
  } drive_result_t;

  drive_result_t expected_drive_q[$];

  // Shadow of the controller state and its registers
  logic [PERIOD_W-1:0] period_ms;
  logic [DUTY_W-1:0]   step_size;
  logic [DUTY_W-1:0]   duty_now;
  logic                panel_bit;
  logic                up_pend, down_pend, deploy_pend, retract_pend;
  logic                pin_level;
  logic [TIME_W-1:0]   next_toggle;

  function automatic void reset_model();
    period_ms    = PERIOD_RST;
    step_size    = STEP_RST;
    duty_now     = '0;
    panel_bit    = 1'b0;
    up_pend      = 1'b0;
    down_pend    = 1'b0;
    deploy_pend  = 1'b0;
    retract_pend = 1'b0;
    pin_level    = 1'b0;
    next_toggle  = TIME_W'(PERIOD_RST);
  endfunction

  // Software PWM: hold the pin at the ends of the duty range, else toggle
  // once the tick time is past the next change point.
  function automatic void advance_pin(input logic [DUTY_W-1:0] d,
                                      input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] unit;
    unit = TIME_W'(period_ms / 16'd100);
    if (d == '0) begin
      pin_level   = 1'b0;
      next_toggle = t + TIME_W'(period_ms);
    end else if (d == DUTY_FULL) begin
      pin_level   = 1'b1;
      next_toggle = t + TIME_W'(period_ms);
    end else if (t > next_toggle) begin
      if (!pin_level) begin
        pin_level   = 1'b1;
        next_toggle = t + unit * TIME_W'(d);
      end else begin
        pin_level   = 1'b0;
        next_toggle = t + unit * TIME_W'(DUTY_FULL - d);
      end
    end
  endfunction

  function automatic drive_result_t predict_tick(input logic [TIME_W-1:0] t,
                                                 input logic conn, mov,
                                                 input logic up, dn, dep, ret);
    int v;
    up_pend      |= up;
    down_pend    |= dn;
    deploy_pend  |= dep;
    retract_pend |= ret;
    if (!conn) begin
      advance_pin('0, t);
    end else begin
      v = int'(duty_now);
      if (up_pend) begin
        v += int'(step_size);
        up_pend = 1'b0;
      end
      if (down_pend) begin
        v -= int'(step_size);
        down_pend = 1'b0;
      end
      if (v > int'(DUTY_FULL)) v = int'(DUTY_FULL);
      if (v < 0) v = 0;
      duty_now = DUTY_W'(v);
      if (!mov && (deploy_pend || retract_pend)) begin
        panel_bit    = ~panel_bit;
        duty_now     = '0;
        deploy_pend  = 1'b0;
        retract_pend = 1'b0;
      end
      if (mov && ((panel_bit && retract_pend) || deploy_pend)) advance_pin(duty_now, t);
      else advance_pin('0, t);
    end
    return '{pin_level, duty_now, panel_bit};
  endfunction

  function automatic int check_field(input string name, input int want, input int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : monitor
    drive_result_t want;
    int            errs;
    int            pushed;
    int            popped;
    if (!rst_n) begin
      reset_model();
      expected_drive_q.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      errs   = 0;
      pushed = 0;
      popped = 0;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PERIOD: period_ms = cfg_wdata;
          CFG_STEP:   step_size = cfg_wdata[DUTY_W-1:0];
          default: begin
          end
        endcase
      end
      // check the result before queuing this edge's request
      if (out_valid && out_ready) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual on=%0b speed=%0d panel=%0b",
                   $time, out_drive_on, out_drive_speed, out_panel_toggled_state);
          errs++;
        end else begin
          want   = expected_drive_q.pop_front();
          popped = 1;
          errs += check_field("drive_on", want.drive_on, out_drive_on);
          errs += check_field("drive_speed", want.speed, out_drive_speed);
          errs += check_field("panel_toggled_state", want.panel, out_panel_toggled_state);
        end
      end
      if (in_valid && in_ready) begin
        expected_drive_q.push_back(predict_tick(in_time_ms, in_connected, in_moving,
                                                in_speed_up_req, in_speed_down_req,
                                                in_deploy_req, in_retract_req));
        pushed = 1;
      end
      fail_count  <= fail_count + errs;
      outstanding <= outstanding + pushed - popped;
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Panel motor PWM controller testbench
// Drives directed and random control ticks through several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb import pmpc_pkg::*;;

  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD  = 60;    // long result back-pressure, in cycles

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_addr;
  logic [PERIOD_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [TIME_W-1:0]   in_time_ms;
  logic                in_connected;
  logic                in_moving;
  logic                in_speed_up_req;
  logic                in_speed_down_req;
  logic                in_deploy_req;
  logic                in_retract_req;
  logic                out_valid;
  logic                out_ready;
  logic                out_drive_on;
  logic [DUTY_W-1:0]   out_drive_speed;
  logic                out_panel_toggled_state;

  int fail_count;
  int outstanding;

  // Stimulus shaping for the sender and the receiver
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  logic [TIME_W-1:0] tick_time;
  bit                link_up;
  bit                in_motion;

  panel_motor_pwm_controller_core DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_addr                (cfg_addr),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_time_ms              (in_time_ms),
    .in_connected            (in_connected),
    .in_moving               (in_moving),
    .in_speed_up_req         (in_speed_up_req),
    .in_speed_down_req       (in_speed_down_req),
    .in_deploy_req           (in_deploy_req),
    .in_retract_req          (in_retract_req),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_drive_on            (out_drive_on),
    .out_drive_speed         (out_drive_speed),
    .out_panel_toggled_state (out_panel_toggled_state)
  );

  pmpc_drive_checker u_drive_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_addr                (cfg_addr),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_time_ms              (in_time_ms),
    .in_connected            (in_connected),
    .in_moving               (in_moving),
    .in_speed_up_req         (in_speed_up_req),
    .in_speed_down_req       (in_speed_down_req),
    .in_deploy_req           (in_deploy_req),
    .in_retract_req          (in_retract_req),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_drive_on            (out_drive_on),
    .out_drive_speed         (out_drive_speed),
    .out_panel_toggled_state (out_panel_toggled_state),
    .fail_count              (fail_count),
    .outstanding             (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one tick request. Keep valid high from the previous request unless
  // a gap is drawn; drop it only for the gap so it never falls and rises in
  // one step. Return right after the accepting edge.
  task automatic send_tick(input logic [TIME_W-1:0] t, input logic conn, mov,
                           input logic up, dn, dep, ret);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    in_time_ms        <= t;
    in_connected      <= conn;
    in_moving         <= mov;
    in_speed_up_req   <= up;
    in_speed_down_req <= dn;
    in_deploy_req     <= dep;
    in_retract_req    <= ret;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random tick: a panel with long connected / unconnected and moving / resting runs and
  // time walking forward by a fraction of the period, so the PWM really
  // toggles. A few ticks jump anywhere, go backward or sit near the wrap.
  task automatic random_tick(input int period);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) tick_time = $urandom();
    else if (r < 7) tick_time = 32'hFFFF_FFFF - $urandom_range(0, 3 * period);
    else if (r < 10) tick_time = tick_time - $urandom_range(0, period);
    else tick_time = tick_time + $urandom_range(0, period / 4);
    if ($urandom_range(0, 29) == 0) link_up = !link_up;
    if ($urandom_range(0, 9) == 0) in_motion = !in_motion;
    send_tick(tick_time, link_up, in_motion,
              $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 10,
              $urandom_range(0, 99) < 6, $urandom_range(0, 99) < 6);
  endtask

  // Pause the sender until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Reprogram both registers on an idle block, then run a random stretch.
  // hold_at picks the request at which the receiver starts a long hold.
  task automatic run_phase(input logic [PERIOD_W-1:0] period,
                           input logic [DUTY_W-1:0] step,
                           input int snd_pct, rcv_pct, count, hold_at);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_addr  <= CFG_STEP;
    cfg_wdata <= PERIOD_W'(step);
    @(posedge clk);
    cfg_we    <= 1'b0;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      random_tick(period);
    end
  endtask

  // Receiver: random back-pressure, plus a long hold on request that lets
  // the pipeline fill and stall the request side.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_addr          = CFG_PERIOD;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_time_ms        = '0;
    in_connected      = 1'b0;
    in_moving         = 1'b0;
    in_speed_up_req   = 1'b0;
    in_speed_down_req = 1'b0;
    in_deploy_req     = 1'b0;
    in_retract_req    = 1'b0;
    hold_req          = 1'b0;
    send_idle_pct     = 30;
    recv_idle_pct     = 70;
    link_up           = 1'b1;
    in_motion         = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks under the reset register values (period 1000, step 10).
    // Disconnected: latch every request, consume none; also the top time value.
    send_tick(32'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 0, 0, 0);
    // Connect at rest: up and down cancel, pending panel request toggles it
    send_tick(32'd10, 1'b1, 1'b0, 1'b0, 0, 0, 0);
    // Step up past full duty so the clamp at 100 engages
    for (int i = 0; i < 11; i++) send_tick(32'd20 + i, 1'b1, 1'b0, 1'b1, 0, 0, 0);
    // Deploy while moving: full duty holds the pin high
    send_tick(32'd100, 1'b1, 1'b1, 1'b0, 0, 1'b1, 0);
    // Drop to 90 and walk time across the change points
    send_tick(32'd200, 1'b1, 1'b1, 1'b0, 1'b1, 0, 0);
    send_tick(32'd1200, 1'b1, 1'b1, 1'b0, 0, 0, 0);
    send_tick(32'd1301, 1'b1, 1'b1, 1'b0, 0, 0, 0);
    // Stop moving with deploy still pending: toggle back, duty to zero
    send_tick(32'd1400, 1'b1, 1'b0, 1'b0, 0, 0, 0);
    // Retract while moving with the panel bit clear: no drive
    send_tick(32'd1500, 1'b1, 1'b1, 1'b0, 0, 0, 1'b1);
    send_tick(32'd1600, 1'b1, 1'b0, 1'b0, 0, 0, 0);
    // Retract while moving with the panel bit set: drive at low duty
    send_tick(32'd1700, 1'b1, 1'b1, 1'b1, 0, 0, 1'b1);
    send_tick(32'd2700, 1'b1, 1'b1, 1'b0, 0, 0, 0);
    // Step down to zero and then below it, so the low clamp engages
    send_tick(32'd2900, 1'b1, 1'b1, 1'b0, 1'b1, 0, 0);
    send_tick(32'd3000, 1'b1, 1'b1, 1'b0, 1'b1, 0, 0);
    tick_time = 32'd3000;

    // Random phases: sender 30 / receiver 70, then the reverse, then no idling.
    // Register settings cover both ends of each range and a step above 100.
    run_phase(16'd1000, 7'd10, 30, 70, 130, 40);
    run_phase(16'd65535, 7'd100, 30, 70, 100, -1);
    run_phase(16'd100, 7'd1, 70, 30, 100, -1);
    run_phase(16'd4321, 7'd127, 70, 30, 100, -1);
    run_phase(PERIOD_W'($urandom_range(100, 65535)), DUTY_W'($urandom_range(1, 100)),
              0, 0, 100, 30);
    run_phase(16'd100, 7'd100, 0, 0, 100, -1);

    // Let the last results drain, then allow for the pipeline depth
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
